// ===== rtl/rgbhsv_pkg.sv =====
package rgbhsv_pkg;

  // Field widths of the pixel and result streams
  localparam int CH_W  = 8;
  localparam int HUE_W = 15;
  localparam int SAT_W = 16;

  // Divisors are twice a channel value, so they fit in one more bit
  localparam int DIV_W = CH_W + 1;

  // Saturation dividend is (2*d << 16) + max
  localparam int SAT_AW = CH_W + SAT_W + 2;
  // Saturation quotient reaches 65536 for a fully saturated pixel
  localparam int SAT_QW = SAT_W + 1;

  // Hue numerator before fractional scaling: base*d + 60*(pos-neg)
  localparam int HNUM_W = 18;

  // Hue sector offsets in degrees
  localparam logic [8:0] BASE_RED      = 9'd0;
  localparam logic [8:0] BASE_RED_WRAP = 9'd360;
  localparam logic [8:0] BASE_GREEN    = 9'd120;
  localparam logic [8:0] BASE_BLUE     = 9'd240;
  localparam logic [6:0] DEG_PER_SECT  = 7'd60;

  localparam logic [SAT_W-1:0] SAT_MAX = {SAT_W{1'b1}};

endpackage

// ===== rtl/rgb_to_hsv.sv =====
// RGB to HSV converter. Takes one 8-bit RGB pixel per transfer and returns
// hue (degrees, HUE_FRAC_BITS fractional bits), saturation (Q0.16, 1.0 reads
// as 65535) and value (largest channel), all rounded to nearest. Gray and
// black pixels give hue 0 and saturation 0. The block accepts a pixel every
// clock unless output back-pressure holds the pipeline. The pipeline has one
// channel compare stage, one numerator setup stage, then the two restoring
// dividers of QW = max(HUE_FRAC_BITS + 9, 17) quotient bits, which retire one
// quotient bit per pipeline stage, and one output stage. Back-pressure on the
// output side stalls only stages that hold data, so bubbles are squeezed out.
module rgb_to_hsv #(
  parameter int HUE_FRAC_BITS = 6
) (
  input  logic        clk,
  input  logic        rst,
  // input pixel stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // red_in[7:0], green_in[15:8], blue_in[23:16]
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // hue_out[14:0], sat_out[30:15], val_out[38:31], 0
);
  import rgbhsv_pkg::*;

  localparam int QW  = (HUE_FRAC_BITS + 9 > SAT_QW) ? HUE_FRAC_BITS + 9 : SAT_QW;
  localparam int HAW = HUE_FRAC_BITS + 19;
  localparam int NS  = QW + 2;
  localparam logic [QW-1:0] HUE_FULL = QW'(360 << HUE_FRAC_BITS);

  // Stage control
  logic          valid [NS];
  logic          adv   [NS];
  logic          valid_c;
  logic          adv_c;

  // Divider payload, stage 0 is the setup register
  logic [DIV_W-1:0] rem_h  [QW+1];
  logic [QW-1:0]    work_h [QW+1];
  logic [DIV_W-1:0] div_h  [QW+1];
  logic [DIV_W-1:0] rem_s  [QW+1];
  logic [QW-1:0]    work_s [QW+1];
  logic [DIV_W-1:0] div_s  [QW+1];
  logic [CH_W-1:0]  val_p  [QW+1];
  logic             gray_p [QW+1];

  // Output register
  logic [HUE_W-1:0] hue_q;
  logic [SAT_W-1:0] sat_q;
  logic [CH_W-1:0]  val_q;

  // A stage may load when it is empty or its contents move on
  assign adv[NS-1] = !valid[NS-1] || m_tready;
  for (genvar i = 0; i < NS - 1; i++) begin : g_adv
    assign adv[i] = !valid[i] || adv[i+1];
  end
  assign adv_c    = !valid_c || adv[0];
  assign s_tready = adv_c;

  // Compare stage: max/min, spread and sector select
  logic [CH_W-1:0]   red, green, blue, mx, mn, dl, pos, neg;
  logic [8:0]        base;
  logic [CH_W-1:0]   mx_c, dl_c, pos_c, neg_c;
  logic [8:0]        base_c;

  always_comb begin
    red   = s_tdata[7:0];
    green = s_tdata[15:8];
    blue  = s_tdata[23:16];
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx)  mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn)  mn = blue;
    dl = mx - mn;
    // ties go to red, then green
    if (mx == red) begin
      pos  = green;
      neg  = blue;
      base = (green >= blue) ? BASE_RED : BASE_RED_WRAP;
    end else if (mx == green) begin
      pos  = blue;
      neg  = red;
      base = BASE_GREEN;
    end else begin
      pos  = red;
      neg  = green;
      base = BASE_BLUE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_c <= 1'b0;
    end else if (adv_c) begin
      valid_c <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      mx_c   <= mx;
      dl_c   <= dl;
      pos_c  <= pos;
      neg_c  <= neg;
      base_c <= base;
    end
  end

  // Setup stage: hue numerator and both rounded dividends
  logic [HNUM_W-1:0] hnum;
  logic [HAW-1:0]    ahue;
  logic [SAT_AW-1:0] asat;

  always_comb begin
    hnum = HNUM_W'(base_c) * HNUM_W'(dl_c) + HNUM_W'(DEG_PER_SECT) * HNUM_W'(pos_c)
         - HNUM_W'(DEG_PER_SECT) * HNUM_W'(neg_c);
    // rounded division: (2*N + den) / (2*den)
    ahue = (HAW'(hnum) << (HUE_FRAC_BITS + 1)) + HAW'(dl_c);
    asat = (SAT_AW'(dl_c) << (SAT_W + 1)) + SAT_AW'(mx_c);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[0] <= 1'b0;
    end else if (adv[0]) begin
      valid[0] <= valid_c;
    end
  end

  // Upper dividend bits are below the divisor for every non-gray pixel
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      rem_h[0]  <= DIV_W'(ahue >> QW);
      work_h[0] <= ahue[QW-1:0];
      div_h[0]  <= {dl_c, 1'b0};
      rem_s[0]  <= DIV_W'(asat >> QW);
      work_s[0] <= asat[QW-1:0];
      div_s[0]  <= {mx_c, 1'b0};
      val_p[0]  <= mx_c;
      gray_p[0] <= (dl_c == '0);
    end
  end

  // Restoring division, one quotient bit per stage for hue and saturation
  for (genvar k = 1; k <= QW; k++) begin : g_div
    logic [DIV_W:0] th, ts;
    logic           geh, ges;

    assign th  = {rem_h[k-1], work_h[k-1][QW-1]};
    assign ts  = {rem_s[k-1], work_s[k-1][QW-1]};
    assign geh = th >= {1'b0, div_h[k-1]};
    assign ges = ts >= {1'b0, div_s[k-1]};

    always_ff @(posedge clk) begin
      if (rst) begin
        valid[k] <= 1'b0;
      end else if (adv[k]) begin
        valid[k] <= valid[k-1];
      end
    end

    always_ff @(posedge clk) begin
      if (adv[k]) begin
        rem_h[k]  <= geh ? DIV_W'(th - {1'b0, div_h[k-1]}) : DIV_W'(th);
        work_h[k] <= {work_h[k-1][QW-2:0], geh};
        div_h[k]  <= div_h[k-1];
        rem_s[k]  <= ges ? DIV_W'(ts - {1'b0, div_s[k-1]}) : DIV_W'(ts);
        work_s[k] <= {work_s[k-1][QW-2:0], ges};
        div_s[k]  <= div_s[k-1];
        val_p[k]  <= val_p[k-1];
        gray_p[k] <= gray_p[k-1];
      end
    end
  end

  // Output stage: hue wrap at 360, saturation clamp, gray forced to zero
  logic [QW-1:0]    qh, qs, hue_wrap;
  logic [HUE_W-1:0] hue_next;
  logic [SAT_W-1:0] sat_next;

  always_comb begin
    qh       = work_h[QW];
    qs       = work_s[QW];
    hue_wrap = (qh >= HUE_FULL) ? qh - HUE_FULL : qh;
    hue_next = gray_p[QW] ? '0 : hue_wrap[HUE_W-1:0];
    if (gray_p[QW]) begin
      sat_next = '0;
    end else if (|qs[QW-1:SAT_W]) begin
      sat_next = SAT_MAX;
    end else begin
      sat_next = qs[SAT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid[NS-1] <= 1'b0;
    end else if (adv[NS-1]) begin
      valid[NS-1] <= valid[NS-2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[NS-1]) begin
      hue_q <= hue_next;
      sat_q <= sat_next;
      val_q <= val_p[QW];
    end
  end

  assign m_tvalid = valid[NS-1];
  assign m_tdata  = {1'b0, val_q, sat_q, hue_q};

  // Dividend setup must leave the starting remainder below the divisor
  a_rem_start: assert property (@(posedge clk) disable iff (rst)
    valid[0] && !gray_p[0] |-> (rem_h[0] < div_h[0]) && (rem_s[0] < div_s[0]))
    else $error("divider start remainder not below divisor");

  // Hue stays below a full turn when the field is wide enough to hold it
  a_hue_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (HUE_FRAC_BITS <= 6) |-> hue_q < HUE_W'(360 << HUE_FRAC_BITS))
    else $error("hue not wrapped below 360 degrees");

  // A lit pixel with zero saturation can only be gray, whose hue is zero
  a_gray_hue: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (val_q != '0) && (sat_q == '0) |-> hue_q == '0)
    else $error("zero saturation with nonzero hue");

endmodule
